[design/vcd_pkg.sv]
// Shared types, command codes and constants for the voxel cube draw engine.
`default_nettype none

package vcd_pkg;

	// Cube geometry. The store always holds 64 rows of 8 bits, addressed {z, y}.
	localparam int CUBE_SIZE_DEF = 8;
	localparam int ROW_W         = 8;
	localparam int ROW_COUNT     = 64;
	localparam int COORD_W       = 3;

	// Command codes as they arrive on the action field.
	localparam logic [3:0] ACT_SET_VOXEL   = 4'd0;
	localparam logic [3:0] ACT_CLEAR_VOXEL = 4'd1;
	localparam logic [3:0] ACT_READ_VOXEL  = 4'd2;
	localparam logic [3:0] ACT_SET_PLANE   = 4'd3;
	localparam logic [3:0] ACT_CLEAR_PLANE = 4'd4;
	localparam logic [3:0] ACT_FILL        = 4'd5;
	localparam logic [3:0] ACT_CLEAR       = 4'd6;
	localparam logic [3:0] ACT_SHIFT       = 4'd7;
	localparam logic [3:0] ACT_BOX         = 4'd8;
	localparam logic [3:0] ACT_WRITE_ROW   = 4'd9;

	// Axis codes for plane and shift commands.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Operation classes that the front end hands to the back end.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_VOXEL,
		OP_READ,
		OP_PLANE,
		OP_FILL,
		OP_SHIFT,
		OP_BOX,
		OP_ROW
	} op_t;

	// One classified command.
	typedef struct packed {
		op_t                op;
		logic               value;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [1:0]         axis;
		logic [COORD_W-1:0] plane;
		logic               dir;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic [ROW_W-1:0]   bits;
	} cmd_t;

	// Head of the command queue as seen by the back end.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

endpackage

`default_nettype wire

[design/vcd_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module vcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr_a,
	output logic      [WIDTH-1:0] rd_data_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

`default_nettype wire

[design/vcd_front.sv]
// Front end: classifies incoming commands and queues them for the back end.
`default_nettype none

module vcd_front #(
	parameter int CUBE_SIZE = vcd_pkg::CUBE_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [3:0]         action,
	input  wire logic [2:0]         coord_x,
	input  wire logic [2:0]         coord_y,
	input  wire logic [2:0]         coord_z,
	input  wire logic [1:0]         axis,
	input  wire logic [2:0]         plane_index,
	input  wire logic               direction,
	input  wire logic [2:0]         box_low,
	input  wire logic [2:0]         box_high,
	input  wire logic [7:0]         row_bits,
	input  wire logic               take,
	output vcd_pkg::cmd_head_t      head
);

	localparam logic [3:0] SIZE_L = 4'(CUBE_SIZE);

	vcd_pkg::cmd_t cls;
	logic          voxel_in;
	logic          row_in;
	logic          axis_ok;
	logic          plane_in;
	logic          do_push;

	vcd_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	// Range checks on the incoming coordinates.
	always_comb begin
		voxel_in = ({1'b0, coord_x} < SIZE_L) && ({1'b0, coord_y} < SIZE_L)
			&& ({1'b0, coord_z} < SIZE_L);
		row_in   = ({1'b0, coord_y} < SIZE_L) && ({1'b0, coord_z} < SIZE_L);
		axis_ok  = (axis == vcd_pkg::AXIS_X) || (axis == vcd_pkg::AXIS_Y)
			|| (axis == vcd_pkg::AXIS_Z);
		plane_in = axis_ok && ({1'b0, plane_index} < SIZE_L);
	end

	// Classify the command; an out-of-range, malformed or unknown command becomes a no-op.
	always_comb begin
		cls.op    = vcd_pkg::OP_NOP;
		cls.value = 1'b0;
		cls.x     = coord_x;
		cls.y     = coord_y;
		cls.z     = coord_z;
		cls.axis  = axis;
		cls.plane = plane_index;
		cls.dir   = direction;
		cls.lo    = box_low;
		cls.hi    = box_high;
		cls.bits  = row_bits;
		unique case (action)
			vcd_pkg::ACT_SET_VOXEL: begin
				if (voxel_in) cls.op = vcd_pkg::OP_VOXEL;
				cls.value = 1'b1;
			end
			vcd_pkg::ACT_CLEAR_VOXEL: begin
				if (voxel_in) cls.op = vcd_pkg::OP_VOXEL;
			end
			vcd_pkg::ACT_READ_VOXEL: begin
				if (voxel_in) cls.op = vcd_pkg::OP_READ;
			end
			vcd_pkg::ACT_SET_PLANE: begin
				if (plane_in) cls.op = vcd_pkg::OP_PLANE;
				cls.value = 1'b1;
			end
			vcd_pkg::ACT_CLEAR_PLANE: begin
				if (plane_in) cls.op = vcd_pkg::OP_PLANE;
			end
			vcd_pkg::ACT_FILL: begin
				cls.op    = vcd_pkg::OP_FILL;
				cls.value = 1'b1;
			end
			vcd_pkg::ACT_CLEAR: begin
				cls.op = vcd_pkg::OP_FILL;
			end
			vcd_pkg::ACT_SHIFT: begin
				if (axis_ok) cls.op = vcd_pkg::OP_SHIFT;
			end
			vcd_pkg::ACT_BOX: begin
				if (box_low <= box_high) cls.op = vcd_pkg::OP_BOX;
			end
			vcd_pkg::ACT_WRITE_ROW: begin
				if (row_in) cls.op = vcd_pkg::OP_ROW;
			end
			default: begin
				cls.op = vcd_pkg::OP_NOP;
			end
		endcase
	end

	// Two-entry command queue between the front and back ends.
	assign full       = (count_q == 2'd2);
	assign do_push    = push && !full;
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (take) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !take) begin
				count_q <= count_q + 2'd1;
			end else if (take && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= cls;
	end

endmodule

`default_nettype wire

[design/vcd_back.sv]
// Back end: walks the voxel row store for each command and queues the results.
`default_nettype none

module vcd_back #(
	parameter int CUBE_SIZE = vcd_pkg::CUBE_SIZE_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vcd_pkg::cmd_head_t  head,
	output logic                     take,
	input  wire logic                pop,
	output logic                     empty,
	output logic                     point_value
);

	localparam int         AW       = $clog2(vcd_pkg::ROW_COUNT);
	localparam int         CW       = AW + 1;
	localparam logic [3:0] SIZE_L   = 4'(CUBE_SIZE);
	localparam logic [3:0] LAST_L   = 4'(CUBE_SIZE - 1);
	localparam logic [7:0] ROW_MASK = 8'((9'd1 << CUBE_SIZE) - 9'd1);
	localparam logic [CW-1:0] ALL_ROWS = CW'(vcd_pkg::ROW_COUNT);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t        state_q;
	vcd_pkg::cmd_t cmd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rows_q;
	logic          point_q;
	logic [vcd_pkg::ROW_COUNT-1:0] valid_q;

	logic          rd_pend_s1;
	logic [AW-1:0] addr_s1;
	logic          dst_vld_s1;
	logic          src_vld_s1;

	logic          issue;
	logic          done;
	logic          single;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] src_addr;
	logic [2:0]    rz;
	logic [2:0]    ry;
	logic [7:0]    ram_dst;
	logic [7:0]    ram_src;
	logic [7:0]    old_row;
	logic [7:0]    src_row;
	logic [7:0]    new_row;
	logic          wr_en;

	logic [2:0]    wz;
	logic [2:0]    wy;
	logic          in_row;
	logic          src_ok;
	logic [7:0]    bit_x;
	logic [7:0]    bit_p;
	logic [7:0]    span;
	logic [7:0]    pts;
	logic [7:0]    box_add;
	logic          y_end;
	logic          z_end;
	logic          y_in;
	logic          z_in;

	logic          res_slot_q [2];
	logic          res_wr_q;
	logic          res_rd_q;
	logic [1:0]    res_cnt_q;
	logic          res_push;
	logic          res_val;
	logic          res_pop;

	// Handshake with the command queue and end of a walk.
	assign take  = (state_q == S_IDLE) && head.valid && (res_cnt_q != 2'd2);
	assign issue = (state_q == S_RUN) && (cnt_q != rows_q);
	assign done  = (state_q == S_RUN) && (cnt_q == rows_q) && !rd_pend_s1;

	// Read addresses for the row under work and the row it shifts from.
	always_comb begin
		single = (cmd_q.op == vcd_pkg::OP_VOXEL) || (cmd_q.op == vcd_pkg::OP_READ)
			|| (cmd_q.op == vcd_pkg::OP_ROW);
		if (single) begin
			rd_addr = {cmd_q.z, cmd_q.y};
		end else if ((cmd_q.op == vcd_pkg::OP_SHIFT) && cmd_q.dir) begin
			rd_addr = ~cnt_q[AW-1:0];
		end else begin
			rd_addr = cnt_q[AW-1:0];
		end
		rz = rd_addr[5:3];
		ry = rd_addr[2:0];
		unique case (cmd_q.axis)
			vcd_pkg::AXIS_Y: src_addr = {rz, cmd_q.dir ? ry - 3'd1 : ry + 3'd1};
			vcd_pkg::AXIS_Z: src_addr = {cmd_q.dir ? rz - 3'd1 : rz + 3'd1, ry};
			default:         src_addr = rd_addr;
		endcase
	end

	vcd_ram #(
		.WIDTH(vcd_pkg::ROW_W),
		.DEPTH(vcd_pkg::ROW_COUNT)
	) u_rows (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (addr_s1),
		.wr_data  (new_row),
		.rd_addr_a(rd_addr),
		.rd_data_a(ram_dst),
		.rd_addr_b(src_addr),
		.rd_data_b(ram_src)
	);

	// Rows never written since reset read as dark.
	assign old_row = dst_vld_s1 ? ram_dst : 8'h00;
	assign src_row = src_vld_s1 ? ram_src : 8'h00;
	assign wr_en   = rd_pend_s1 && (cmd_q.op != vcd_pkg::OP_READ);

	// Row geometry terms for the row whose data has come back.
	always_comb begin
		wz     = addr_s1[5:3];
		wy     = addr_s1[2:0];
		in_row = ({1'b0, wz} < SIZE_L) && ({1'b0, wy} < SIZE_L);
		bit_x  = 8'd1 << cmd_q.x;
		bit_p  = 8'd1 << cmd_q.plane;
		span   = (8'hFF << cmd_q.lo) & (8'hFF >> (3'd7 - cmd_q.hi));
		pts    = (8'd1 << cmd_q.lo) | (8'd1 << cmd_q.hi);
		y_end  = (wy == cmd_q.lo) || (wy == cmd_q.hi);
		z_end  = (wz == cmd_q.lo) || (wz == cmd_q.hi);
		y_in   = (wy >= cmd_q.lo) && (wy <= cmd_q.hi);
		z_in   = (wz >= cmd_q.lo) && (wz <= cmd_q.hi);
		box_add = ((y_end && z_end) ? span : 8'h00)
			| ((z_end && y_in) ? pts : 8'h00)
			| ((y_end && z_in) ? pts : 8'h00);
		if (cmd_q.axis == vcd_pkg::AXIS_Y) begin
			src_ok = cmd_q.dir ? (wy != 3'd0) : ({1'b0, wy} < LAST_L);
		end else begin
			src_ok = cmd_q.dir ? (wz != 3'd0) : ({1'b0, wz} < LAST_L);
		end
	end

	// New contents of the row under work.
	always_comb begin
		new_row = old_row;
		unique case (cmd_q.op)
			vcd_pkg::OP_VOXEL: begin
				new_row = cmd_q.value ? (old_row | bit_x) : (old_row & ~bit_x);
			end
			vcd_pkg::OP_ROW: begin
				new_row = cmd_q.bits & ROW_MASK;
			end
			vcd_pkg::OP_FILL: begin
				if (in_row) new_row = cmd_q.value ? ROW_MASK : 8'h00;
			end
			vcd_pkg::OP_PLANE: begin
				if (in_row) begin
					unique case (cmd_q.axis)
						vcd_pkg::AXIS_X: begin
							new_row = cmd_q.value ? (old_row | bit_p) : (old_row & ~bit_p);
						end
						vcd_pkg::AXIS_Y: begin
							if (wy == cmd_q.plane) begin
								new_row = cmd_q.value ? (old_row | ROW_MASK)
									: (old_row & ~ROW_MASK);
							end
						end
						default: begin
							if (wz == cmd_q.plane) begin
								new_row = cmd_q.value ? (old_row | ROW_MASK)
									: (old_row & ~ROW_MASK);
							end
						end
					endcase
				end
			end
			vcd_pkg::OP_SHIFT: begin
				if (in_row) begin
					if (cmd_q.axis == vcd_pkg::AXIS_X) begin
						new_row = (old_row & ~ROW_MASK) | (cmd_q.dir
							? ((old_row << 1) & ROW_MASK)
							: ((old_row >> 1) & (ROW_MASK >> 1)));
					end else begin
						new_row = (old_row & ~ROW_MASK) | (src_ok ? (src_row & ROW_MASK)
							: 8'h00);
					end
				end
			end
			vcd_pkg::OP_BOX: begin
				if (in_row) new_row = old_row | (box_add & ROW_MASK);
			end
			default: begin
				new_row = old_row;
			end
		endcase
	end

	// Sequencer state, walk counter and captured read bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rows_q  <= '0;
			point_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						cnt_q   <= '0;
						point_q <= 1'b0;
						if ((head.cmd.op == vcd_pkg::OP_VOXEL)
							|| (head.cmd.op == vcd_pkg::OP_READ)
							|| (head.cmd.op == vcd_pkg::OP_ROW)) begin
							rows_q <= CW'(1);
						end else begin
							rows_q <= ALL_ROWS;
						end
						if (head.cmd.op != vcd_pkg::OP_NOP) state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (issue) cnt_q <= cnt_q + CW'(1);
					if (rd_pend_s1 && (cmd_q.op == vcd_pkg::OP_READ)) begin
						point_q <= old_row[cmd_q.x];
					end
					if (done) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Read pipeline control and per-row valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			valid_q    <= '0;
		end else begin
			rd_pend_s1 <= issue;
			if (wr_en) valid_q[addr_s1] <= 1'b1;
		end
	end

	// Command and read pipeline payload.
	always_ff @(posedge clk) begin
		if (take) cmd_q <= head.cmd;
		addr_s1    <= rd_addr;
		dst_vld_s1 <= valid_q[rd_addr];
		src_vld_s1 <= valid_q[src_addr];
	end

	// Two-entry result queue; a no-op answers at once with a zero.
	assign res_push    = (take && (head.cmd.op == vcd_pkg::OP_NOP)) || done;
	assign res_val     = done ? point_q : 1'b0;
	assign empty       = (res_cnt_q == 2'd0);
	assign res_pop     = pop && !empty;
	assign point_value = res_slot_q[res_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) res_wr_q <= !res_wr_q;
			if (res_pop) res_rd_q <= !res_rd_q;
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) res_slot_q[res_wr_q] <= res_val;
	end

endmodule

`default_nettype wire

[design/voxel_cube_draw_engine.sv]
// Voxel cube draw engine: 64 rows of 8 voxels, all dark after reset (valid bits, no sweep).
// Flow: a no-op beat answers without a walk, a one-row command walks its one row,
// and a plane, fill, shift or box command walks all 64 rows, one stored row per cycle.
// Occupancy: one command in the back end at a time, limited by the single row write port;
// the back end takes the next command only once the last walk is done.
// Reset: arst_n clears the queues, the sequencer and the row valid bits at once.
`default_nettype none

module voxel_cube_draw_engine #(
	parameter int CUBE_SIZE = vcd_pkg::CUBE_SIZE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [3:0] action,
	input  wire logic [2:0] coord_x,
	input  wire logic [2:0] coord_y,
	input  wire logic [2:0] coord_z,
	input  wire logic [1:0] axis,
	input  wire logic [2:0] plane_index,
	input  wire logic       direction,
	input  wire logic [2:0] box_low,
	input  wire logic [2:0] box_high,
	input  wire logic [7:0] row_bits,
	output logic            empty,
	input  wire logic       pop,
	output logic            point_value
);

	vcd_pkg::cmd_head_t front_head;
	logic               back_take;

	// Command classification and queue.
	vcd_front #(
		.CUBE_SIZE(CUBE_SIZE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.axis       (axis),
		.plane_index(plane_index),
		.direction  (direction),
		.box_low    (box_low),
		.box_high   (box_high),
		.row_bits   (row_bits),
		.take       (back_take),
		.head       (front_head)
	);

	// Row store walker and result queue.
	vcd_back #(
		.CUBE_SIZE(CUBE_SIZE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (front_head),
		.take       (back_take),
		.pop        (pop),
		.empty      (empty),
		.point_value(point_value)
	);

`ifndef ASSERT_OFF
	a_take_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		back_take |-> front_head.valid)
		else $error("back end took a command from an empty queue");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> front_head.valid)
		else $error("command queue full without a head entry");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("command queue became full without a push beat");
`endif

endmodule

`default_nettype wire
